@@ rtl/assert_macros.svh @@
// Assertion macros shared by the block reversal cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is asserted (reset active low).
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ rtl/brc_pkg.sv @@
// Types and constants of the block reversal cipher.
package brc_pkg;

    localparam int CHAR_W     = 21;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SHRUNK = 2;

    localparam logic [CFG_DATA_W-1:0] INIT_SIZE_RST = 6'd4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK    = 2'd1;

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } t_brc_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic load;
    } t_brc_cmd;

    typedef struct packed {
        logic block_done;
        logic idx_zero;
        logic out_free;
    } t_brc_sts;

endpackage

@@ rtl/brc_ctrl.sv @@
// Fill/drain controller of the block reversal cipher.
`include "assert_macros.svh"
module brc_ctrl import brc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_brc_sts i_sts,
    output t_brc_cmd o_cmd
);

    t_brc_state r_state;
    t_brc_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_FILL: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
                if (i_in_valid && i_sts.block_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.load = i_sts.out_free;
                // last read of the block goes out, back to collecting
                if (i_sts.out_free && i_sts.idx_zero) begin
                    n_state = S_FILL;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    `ASSERT_PROP(a_drain_entry, i_clk, i_rst_n,
        (r_state == S_FILL) && !(i_in_valid && i_sts.block_done) |=> (r_state == S_FILL))
    `ASSERT_PROP(a_drain_exit, i_clk, i_rst_n,
        (r_state == S_DRAIN) && !(i_sts.out_free && i_sts.idx_zero) |=> (r_state == S_DRAIN))

endmodule

@@ rtl/brc_datapath.sv @@
// Block buffer, counters and output register of the block reversal cipher.
`include "assert_macros.svh"
module brc_datapath import brc_pkg::*; #(
    parameter int MAX_BLOCK = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_init_size,
    input  logic                  i_shrink_en,
    input  logic [CHAR_W-1:0]     i_in_char,
    input  logic                  i_text_end,
    input  logic                  i_out_ready,
    input  t_brc_cmd              i_cmd,
    output t_brc_sts              o_sts,
    output logic                  o_out_valid,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic                  o_block_last,
    output logic                  o_text_last
);

    localparam int IDX_W      = $clog2(MAX_BLOCK);
    localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
    localparam int INIT_EXT_W = CFG_DATA_W + 1;

    logic [CHAR_W-1:0] r_mem [MAX_BLOCK];

    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_size;
    logic              r_in_text;
    logic              r_last;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_block_last;
    logic              r_text_last;

    logic [INIT_EXT_W-1:0] init_ext;
    logic [CNT_W-1:0]      size_init;
    logic [CNT_W-1:0]      size_eff;
    logic [CNT_W-1:0]      fill_eff;
    logic [CNT_W-1:0]      fill_next;
    logic [CNT_W-1:0]      size_after;
    logic [IDX_W-1:0]      wr_idx;
    logic                  block_done;

    // size of zero acts as one, above the buffer depth acts as the depth
    always_comb begin
        init_ext = {1'b0, i_init_size};
        if (init_ext == '0) begin
            size_init = CNT_W'(1);
        end else if (init_ext > INIT_EXT_W'(MAX_BLOCK)) begin
            size_init = CNT_W'(MAX_BLOCK);
        end else begin
            size_init = CNT_W'(init_ext);
        end
    end

    // first character of a text starts from the programmed size
    assign size_eff   = r_in_text ? r_size : size_init;
    assign fill_eff   = r_in_text ? r_fill : '0;
    assign fill_next  = fill_eff + CNT_W'(1);
    assign wr_idx     = fill_eff[IDX_W-1:0];
    assign block_done = (fill_next >= size_eff) || i_text_end;
    assign size_after = (i_shrink_en && (size_eff > CNT_W'(MIN_SHRUNK)))
                        ? size_eff - CNT_W'(1) : size_eff;

    assign o_sts.block_done = block_done;
    assign o_sts.idx_zero   = (r_rd_idx == '0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[wr_idx] <= i_in_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_size    <= CNT_W'(1);
            r_in_text <= 1'b0;
            r_last    <= 1'b0;
            r_rd_idx  <= '0;
        end else if (i_cmd.accept) begin
            r_size    <= block_done ? size_after : size_eff;
            r_fill    <= block_done ? '0 : fill_next;
            r_in_text <= !(block_done && i_text_end);
            if (block_done) begin
                r_last   <= i_text_end;
                r_rd_idx <= wr_idx;
            end
        end else if (i_cmd.load && (r_rd_idx != '0)) begin
            r_rd_idx <= r_rd_idx - IDX_W'(1);
        end
    end

    // output register doubles as the buffer's registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_char   <= r_mem[r_rd_idx];
            r_block_last <= (r_rd_idx == '0);
            r_text_last  <= (r_rd_idx == '0) && r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_block_last = r_block_last;
    assign o_text_last  = r_text_last;

    `ASSERT_PROP(a_last_read_marks_end, i_clk, i_rst_n,
        i_cmd.load && (r_rd_idx == '0) |=> o_out_valid && o_block_last)
    `ASSERT_NEVER(a_text_last_in_block, i_clk, i_rst_n,
        o_out_valid && o_text_last && !o_block_last)
    `ASSERT_PROP(a_fill_below_size, i_clk, i_rst_n,
        r_in_text |-> (r_fill < r_size))
    `ASSERT_NEVER(a_accept_while_drain, i_clk, i_rst_n,
        i_cmd.accept && i_cmd.load)

endmodule

@@ rtl/block_reversal_cipher.sv @@
// Block reversal cipher: top level with configuration registers.
// Characters are collected into a MAX_BLOCK-deep buffer, one accepted item per
// cycle while a block fills. When the block is full, or text_end arrives, the
// block is read back in reverse order from the buffer's single read port, one
// result item per cycle while the output side takes them; no input is taken
// during that drain. Once the closing item is accepted the controller enters its
// drain state, and each result item of the block is then delivered through the
// output register. block_last flags the final character of each block and
// text_last the final character of the text. initial_block_size is clamped to
// 1..MAX_BLOCK and is loaded at the first character of each text; with
// shrink_enable set the size drops by one per block while above two.
// MAX_BLOCK may range from 2 to 64. Configuration writes are always ready.
module block_reversal_cipher import brc_pkg::*; #(
    parameter int MAX_BLOCK = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_W-1:0]     i_in_char,
    input  logic                  i_text_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic                  o_block_last,
    output logic                  o_text_last
);

    logic [CFG_DATA_W-1:0] r_init_size;
    logic                  r_shrink_en;

    t_brc_cmd cmd;
    t_brc_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_size <= INIT_SIZE_RST;
            r_shrink_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INIT_SIZE: r_init_size <= i_cfg_data;
                CFG_SHRINK:    r_shrink_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    brc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brc_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init_size  (r_init_size),
        .i_shrink_en  (r_shrink_en),
        .i_in_char    (i_in_char),
        .i_text_end   (i_text_end),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_block_last (o_block_last),
        .o_text_last  (o_text_last)
    );

    assign o_in_ready = cmd.in_ready;

endmodule
